// ===== rtl/core/assert_macros.svh =====
// Assertion shorthands for the fuzzy name scorer.
// Define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, quiet during reset.
`define FNMS_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("fnms assertion failed");

// Next-cycle implication, quiet during reset.
`define FNMS_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("fnms assertion failed");

`else

`define FNMS_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons)
`define FNMS_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons)

`endif

`endif

// ===== rtl/core/fnms_pkg.sv =====
package fnms_pkg;

	// Field and register widths
	localparam int CHAR_W     = 8;
	localparam int SCORE_W    = 10;
	localparam int FUZZY_W    = 8;
	localparam int POS_W      = 5;
	localparam int BONUS_W    = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;
	localparam int CHARS_PER_REG = CFG_DATA_W / CHAR_W;

	// Query storage limit and default chain length
	localparam int PAT_CHARS       = 16;
	localparam int MAX_PATTERN_DEF = 16;

	// Scoring constants
	localparam logic [BONUS_W-1:0] BONUS_BASE  = 5'd1;
	localparam logic [BONUS_W-1:0] BONUS_START = 5'd15;
	localparam logic [BONUS_W-1:0] BONUS_WORD  = 5'd10;
	localparam logic [BONUS_W-1:0] BONUS_RUN   = 5'd5;
	localparam logic [SCORE_W-1:0] BONUS_PREFIX = 10'd50;
	localparam logic [SCORE_W-1:0] SCORE_EQUAL  = 10'd1000;
	localparam logic [POS_W-1:0]   POS_LIMIT    = 5'd31;
	localparam logic [CHAR_W-1:0]  WORD_JOIN    = 8'h5F;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAT_LO  = 2'd0,
		REG_PAT_HI  = 2'd1,
		REG_PAT_LEN = 2'd2
	} cfg_reg_t;

	// Channel payloads
	typedef struct packed {
		logic [CHAR_W-1:0] name_byte;
		logic              last_byte;
	} name_item_t;

	typedef struct packed {
		logic [SCORE_W-1:0] match_score;
		logic               included;
	} score_item_t;

	// Per-cell status toward the scorer
	typedef struct packed {
		logic tok;
		logic sv;
		logic active;
		logic hit;
		logic armed_next;
		logic tail_hit;
		logic pfx_fail;
	} cell_stat_t;

	// Chain-wide summary for one byte
	typedef struct packed {
		logic active;
		logic hit;
		logic armed_next;
		logic tail_hit;
		logic pfx_fail;
	} chain_sum_t;

	// Fold ASCII upper case to lower case
	function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A)
			r = c + 8'd32;
		return r;
	endfunction

	// Anything but a-z, 0-9 and underscore breaks a word
	function automatic logic is_sep(input logic [CHAR_W-1:0] c);
		logic word;
		word = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h30 && c <= 8'h39) || (c == WORD_JOIN);
		return ~word;
	endfunction

endpackage

// ===== rtl/core/fnms_cell.sv =====
module fnms_cell #(
	parameter int IDX = 0
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step,
	input  logic                                clear,
	input  logic                                wr_en,
	input  logic [fnms_pkg::CHAR_W-1:0]         wr_char,
	input  logic [fnms_pkg::CHAR_W-1:0]         cur_char,
	input  logic [fnms_pkg::POS_W-1:0]          len,
	input  logic [fnms_pkg::POS_W-1:0]          pos,
	input  logic                                tok_in,
	input  logic                                sv_in,
	output fnms_pkg::cell_stat_t                stat
);
	import fnms_pkg::*;

	localparam logic [POS_W-1:0] MY_IDX   = POS_W'(IDX);
	localparam logic [POS_W-1:0] MY_NEXT  = POS_W'(IDX + 1);
	localparam logic             TOK_INIT = (IDX == 0);

	logic [CHAR_W-1:0] char_q;
	logic              tok_q;
	logic              sv_q;
	logic              in_use;
	logic              eq;
	logic              hit;
	logic              tok_nx;
	logic              sv_nx;

	// Compare this cell's query character with the current byte
	assign in_use = MY_IDX < len;
	assign eq     = cur_char == char_q;
	assign hit    = tok_q & in_use & eq;

	// Pass the greedy token on a hit, take it from the left neighbor
	assign tok_nx = (tok_q & ~hit) | tok_in;

	// Shift-and bit; hold while the query is empty
	always_comb begin
		if (len == '0)
			sv_nx = sv_q;
		else
			sv_nx = sv_in & eq & in_use;
	end

	always_comb begin
		stat.tok        = tok_q;
		stat.sv         = sv_q;
		stat.active     = tok_q & in_use;
		stat.hit        = hit;
		stat.armed_next = tok_nx & in_use;
		stat.tail_hit   = sv_nx & (MY_NEXT == len);
		stat.pfx_fail   = in_use & (pos == MY_IDX) & ~eq;
	end

	// Hold query character, token and shift-and bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_q <= '0;
			tok_q  <= TOK_INIT;
			sv_q   <= 1'b0;
		end else begin
			if (wr_en)
				char_q <= wr_char;
			if (clear) begin
				tok_q <= TOK_INIT;
				sv_q  <= 1'b0;
			end else if (step) begin
				tok_q <= tok_nx;
				sv_q  <= sv_nx;
			end
		end
	end

endmodule

// ===== rtl/core/fnms_score.sv =====
module fnms_score (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic                        last,
	input  logic [fnms_pkg::POS_W-1:0]  len,
	input  logic                        sep,
	input  fnms_pkg::chain_sum_t        sum,
	output logic [fnms_pkg::POS_W-1:0]  pos,
	output fnms_pkg::score_item_t       result
);
	import fnms_pkg::*;

	logic [FUZZY_W-1:0] fuzzy_q;
	logic               prev_m_q;
	logic               prev_s_q;
	logic               seen_q;
	logic               pfx_q;
	logic [POS_W-1:0]   pos_q;

	logic [BONUS_W-1:0] add;
	logic [FUZZY_W:0]   fz_sum;
	logic [FUZZY_W-1:0] fz_nx;
	logic               pm_nx;
	logic               ps_nx;
	logic               seen_nx;
	logic               pfx_nx;
	logic [POS_W-1:0]   pos_nx;
	logic               is_pfx;
	logic               is_eq;

	assign pos = pos_q;

	// Pick the bonus for a greedy hit
	always_comb begin
		priority if (pos_q == '0)
			add = BONUS_BASE + BONUS_START;
		else if (prev_s_q)
			add = BONUS_BASE + BONUS_WORD;
		else if (prev_m_q)
			add = BONUS_BASE + BONUS_RUN;
		else
			add = BONUS_BASE;
	end

	// Accumulate with saturation, advance the per-name flags
	always_comb begin
		fz_sum  = {1'b0, fuzzy_q} + (FUZZY_W + 1)'(add);
		fz_nx   = sum.hit ? (fz_sum[FUZZY_W] ? '1 : fz_sum[FUZZY_W-1:0]) : fuzzy_q;
		pm_nx   = sum.active ? sum.hit : prev_m_q;
		ps_nx   = sum.active ? sep : prev_s_q;
		seen_nx = seen_q | sum.tail_hit;
		pfx_nx  = pfx_q & ~sum.pfx_fail;
		pos_nx  = (pos_q == POS_LIMIT) ? pos_q : pos_q + 1'b1;
		is_pfx  = pfx_nx && (pos_nx >= len);
		is_eq   = pfx_nx && (pos_nx == len);
	end

	// Form the result of a name ending on this byte
	always_comb begin
		priority if (len == '0) begin
			result.match_score = '0;
			result.included    = 1'b1;
		end else if (seen_nx) begin
			result.included = 1'b1;
			if (is_eq)
				result.match_score = SCORE_EQUAL;
			else
				result.match_score = {{(SCORE_W - FUZZY_W){1'b0}}, fz_nx}
					+ (is_pfx ? BONUS_PREFIX : '0);
		end else if (!sum.armed_next) begin
			result.match_score = {{(SCORE_W - FUZZY_W){1'b0}}, fz_nx};
			result.included    = 1'b1;
		end else begin
			result.match_score = '0;
			result.included    = 1'b0;
		end
	end

	// Advance per-name state, clear it after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fuzzy_q  <= '0;
			prev_m_q <= 1'b0;
			prev_s_q <= 1'b1;
			seen_q   <= 1'b0;
			pfx_q    <= 1'b1;
			pos_q    <= '0;
		end else if (step) begin
			if (last) begin
				fuzzy_q  <= '0;
				prev_m_q <= 1'b0;
				prev_s_q <= 1'b1;
				seen_q   <= 1'b0;
				pfx_q    <= 1'b1;
				pos_q    <= '0;
			end else begin
				fuzzy_q  <= fz_nx;
				prev_m_q <= pm_nx;
				prev_s_q <= ps_nx;
				seen_q   <= seen_nx;
				pfx_q    <= pfx_nx;
				pos_q    <= pos_nx;
			end
		end
	end

endmodule

// ===== rtl/core/fuzzy_name_match_scorer_top.sv =====
// Channel   Direction  Handshake              Payload
// name      in         name_valid/name_stall  name_item (name_byte, last_byte)
// score     out        score_valid/score_stall score_item (match_score, included)
// cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One name byte per cycle while the input is not stalled; every cell of the chain updates in the byte's cycle.
// A score appears in the output register in the cycle after the last byte's transfer.
// arst_n clears the query to empty and the per-name state to its start values.
// Input stalls only while a held score is itself stalled; cfg is always ready.

`include "assert_macros.svh"

module fuzzy_name_match_scorer_top #(
	parameter int MAX_PATTERN = fnms_pkg::MAX_PATTERN_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  name_valid,
	output logic                                  name_stall,
	input  fnms_pkg::name_item_t                  name_item,
	output logic                                  score_valid,
	input  logic                                  score_stall,
	output fnms_pkg::score_item_t                 score_item,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [fnms_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [fnms_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import fnms_pkg::*;

	localparam int NCELL = (MAX_PATTERN < PAT_CHARS) ? MAX_PATTERN : PAT_CHARS;

	logic [POS_W-1:0]  len_raw_q;
	logic [POS_W-1:0]  eff_len;
	logic              cfg_we;
	logic              lo_we;
	logic              hi_we;
	logic              step;
	logic              last;
	logic [CHAR_W-1:0] cur_char;
	logic              sep;
	logic [POS_W-1:0]  pos;

	cell_stat_t        stat   [NCELL];
	logic [NCELL-1:0]  wr_v;
	logic [NCELL-1:0]  tok_v;
	logic [NCELL-1:0]  sv_v;
	logic [NCELL-1:0]  hit_v;
	logic [NCELL-1:0]  act_v;
	logic [NCELL-1:0]  arm_v;
	logic [NCELL-1:0]  tail_v;
	logic [NCELL-1:0]  fail_v;
	logic [NCELL-1:0]  tok_in_v;
	logic [NCELL-1:0]  sv_in_v;
	chain_sum_t        sum;
	score_item_t       result;

	logic              score_valid_q;
	score_item_t       score_item_q;

	// Decode configuration writes
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;
	assign lo_we     = cfg_we && (cfg_index == REG_PAT_LO);
	assign hi_we     = cfg_we && (cfg_index == REG_PAT_HI);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			len_raw_q <= '0;
		else if (cfg_we && (cfg_index == REG_PAT_LEN))
			len_raw_q <= cfg_data[POS_W-1:0];
	end

	// Clamp the length to the chain
	assign eff_len = (len_raw_q > POS_W'(NCELL)) ? POS_W'(NCELL) : len_raw_q;

	// Accept a byte unless a finished score is held up
	assign name_stall = score_valid_q & score_stall;
	assign step       = name_valid & ~name_stall;
	assign last       = name_item.last_byte;
	assign cur_char   = fold(name_item.name_byte);
	assign sep        = is_sep(cur_char);

	// Link neighbors: token and shift-and bit move one cell right
	assign tok_in_v = hit_v << 1;
	assign sv_in_v  = (sv_v << 1) | NCELL'(1);

	for (genvar g = 0; g < NCELL; g++) begin : g_cell
		localparam int HALF = g / CHARS_PER_REG;
		localparam int BSEL = g % CHARS_PER_REG;

		assign wr_v[g] = (HALF == 0) ? lo_we : hi_we;

		fnms_cell #(
			.IDX(g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.step     (step),
			.clear    (step & last),
			.wr_en    (wr_v[g]),
			.wr_char  (fold(cfg_data[CHAR_W*BSEL +: CHAR_W])),
			.cur_char (cur_char),
			.len      (eff_len),
			.pos      (pos),
			.tok_in   (tok_in_v[g]),
			.sv_in    (sv_in_v[g]),
			.stat     (stat[g])
		);

		assign tok_v[g]  = stat[g].tok;
		assign sv_v[g]   = stat[g].sv;
		assign hit_v[g]  = stat[g].hit;
		assign act_v[g]  = stat[g].active;
		assign arm_v[g]  = stat[g].armed_next;
		assign tail_v[g] = stat[g].tail_hit;
		assign fail_v[g] = stat[g].pfx_fail;
	end

	// Combine the cells for the scorer
	always_comb begin
		sum.active     = |act_v;
		sum.hit        = |hit_v;
		sum.armed_next = |arm_v;
		sum.tail_hit   = |tail_v;
		sum.pfx_fail   = |fail_v;
	end

	fnms_score u_score (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.last   (last),
		.len    (eff_len),
		.sep    (sep),
		.sum    (sum),
		.pos    (pos),
		.result (result)
	);

	// Hold the score until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			score_valid_q <= 1'b0;
		else if (step && last)
			score_valid_q <= 1'b1;
		else if (!score_stall)
			score_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (step && last)
			score_item_q <= result;
	end

	assign score_valid = score_valid_q;
	assign score_item  = score_item_q;

	// At most one cell matches a byte, and the greedy token sits in one cell at most
	`FNMS_ASSERT_IMP(a_one_hit, clk, arst_n, step, $onehot0(hit_v))
	`FNMS_ASSERT_IMP(a_one_tok, clk, arst_n, 1'b1, $onehot0(tok_v))
	// A held, stalled score blocks the input
	`FNMS_ASSERT_IMP(a_hold_in, clk, arst_n, score_valid_q && score_stall, name_stall)
	// A last byte always yields a score next cycle
	`FNMS_ASSERT_NXT(a_last_out, clk, arst_n, step && last, score_valid_q)

endmodule

// ===== test/fuzzy_name_match_scorer_top_test.sv =====
`timescale 1ns / 1ps

module fuzzy_name_match_scorer_top_test;

	import fnms_pkg::*;

	// Scoring rules as the block is specified
	localparam int QUERY_MAX    = 16;
	localparam int POS_SATURATE = 31;
	localparam int BASE_POINTS  = 1;
	localparam int START_POINTS = 15;
	localparam int WORD_POINTS  = 10;
	localparam int RUN_POINTS   = 5;
	localparam int PREFIX_EXTRA = 50;
	localparam int EQUAL_SCORE  = 1000;
	localparam int FUZZY_CAP    = 255;
	localparam logic [7:0] UNDERSCORE = 8'h5F;

	localparam int QUIET_LIMIT   = 4000;
	localparam int SETTING_BYTES = 66;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        name_valid = 1'b0;
	logic        name_stall;
	name_item_t  name_item = '0;
	logic        score_valid;
	logic        score_stall = 1'b0;
	score_item_t score_item;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	fuzzy_name_match_scorer_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.name_valid  (name_valid),
		.name_stall  (name_stall),
		.name_item   (name_item),
		.score_valid (score_valid),
		.score_stall (score_stall),
		.score_item  (score_item),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// Query as last written
	logic [63:0] query_lo = '0;
	logic [63:0] query_hi = '0;
	logic [4:0]  query_len_reg = '0;

	// Per-name scoring state
	int          cur_match_idx;
	int          cur_fuzzy;
	bit          cur_prev_match;
	bit          cur_prev_sep;
	logic [15:0] cur_window;
	bit          cur_window_hit;
	bit          cur_prefix_ok;
	int          cur_pos;

	score_item_t expected_scores[$];
	score_item_t oldest_score;
	logic [7:0]  name_buf[$];
	int          mismatch_count = 0;
	int          quiet_cycles = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] lower_case(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5A)
			return c + 8'd32;
		return c;
	endfunction

	function automatic bit breaks_word(input logic [7:0] c);
		bit word_char;
		word_char = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h30 && c <= 8'h39) ||
			(c == UNDERSCORE);
		return !word_char;
	endfunction

	function automatic logic [7:0] stored_query_byte(input int i);
		if (i < 8)
			return query_lo[8*i +: 8];
		return query_hi[8*(i-8) +: 8];
	endfunction

	function automatic logic [7:0] query_char(input int i);
		return lower_case(stored_query_byte(i));
	endfunction

	function automatic int eff_query_len();
		int n;
		n = query_len_reg;
		if (n > QUERY_MAX)
			n = QUERY_MAX;
		if (n > MAX_PATTERN_DEF)
			n = MAX_PATTERN_DEF;
		return n;
	endfunction

	task automatic clear_name_state();
		cur_match_idx  = 0;
		cur_fuzzy      = 0;
		cur_prev_match = 1'b0;
		cur_prev_sep   = 1'b1;
		cur_window     = '0;
		cur_window_hit = 1'b0;
		cur_prefix_ok  = 1'b1;
		cur_pos        = 0;
	endtask

	// Advance the scoring state by one name byte; queue a score on the last byte
	task automatic score_name_byte(input name_item_t it);
		logic [7:0]  c;
		logic [15:0] hits;
		logic [15:0] low;
		int          len;
		int          pos;
		int          add;
		int          sc;
		bit          inc;
		bit          is_prefix;
		bit          is_equal;
		score_item_t want;
		c = lower_case(it.name_byte);
		len = eff_query_len();
		pos = cur_pos;
		if (len > 0) begin
			// greedy subsequence
			if (cur_match_idx < len) begin
				if (c == query_char(cur_match_idx)) begin
					add = BASE_POINTS;
					if (pos == 0)
						add += START_POINTS;
					else if (cur_prev_sep)
						add += WORD_POINTS;
					else if (cur_prev_match)
						add += RUN_POINTS;
					cur_fuzzy += add;
					if (cur_fuzzy > FUZZY_CAP)
						cur_fuzzy = FUZZY_CAP;
					cur_prev_match = 1'b1;
					cur_match_idx++;
				end else begin
					cur_prev_match = 1'b0;
				end
				cur_prev_sep = breaks_word(c);
			end
			// shift-and window
			hits = '0;
			for (int i = 0; i < len; i++)
				if (query_char(i) == c)
					hits[i] = 1'b1;
			low = (len >= 16) ? 16'hFFFF : ((16'h1 << len) - 16'h1);
			cur_window = ((cur_window << 1) | 16'h1) & hits & low;
			if (cur_window[len-1])
				cur_window_hit = 1'b1;
			// prefix
			if (pos < len && c != query_char(pos))
				cur_prefix_ok = 1'b0;
		end
		if (cur_pos < POS_SATURATE)
			cur_pos++;
		if (it.last_byte) begin
			sc = 0;
			inc = 1'b0;
			if (len == 0) begin
				inc = 1'b1;
			end else if (cur_window_hit) begin
				is_prefix = cur_prefix_ok && cur_pos >= len;
				is_equal = cur_prefix_ok && cur_pos == len;
				inc = 1'b1;
				sc = cur_fuzzy;
				if (is_prefix)
					sc += PREFIX_EXTRA;
				if (is_equal)
					sc = EQUAL_SCORE;
			end else if (cur_match_idx >= len) begin
				inc = 1'b1;
				sc = cur_fuzzy;
			end
			want.match_score = sc[SCORE_W-1:0];
			want.included = inc;
			expected_scores.push_back(want);
			clear_name_state();
		end
	endtask

	// Check each score transfer and drive a random stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (score_valid && !score_stall) begin
				if (expected_scores.size() == 0) begin
					$display("%0t: unexpected score, expected none, actual score %0d included %0b",
						$time, score_item.match_score, score_item.included);
					mismatch_count++;
				end else begin
					oldest_score = expected_scores.pop_front();
					if (score_item.match_score !== oldest_score.match_score) begin
						$display("%0t: match_score expected %0d actual %0d", $time,
							oldest_score.match_score, score_item.match_score);
						mismatch_count++;
					end
					if (score_item.included !== oldest_score.included) begin
						$display("%0t: included expected %0b actual %0b", $time,
							oldest_score.included, score_item.included);
						mismatch_count++;
					end
				end
			end
			score_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// End the run when no transfer happens for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((name_valid && !name_stall) || (score_valid && !score_stall) ||
				(cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAILURE");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Offer one byte, idling first at random, and hold it until the transfer
	task automatic send_byte(input logic [7:0] b, input logic is_last);
		name_item_t it;
		it.name_byte = b;
		it.last_byte = is_last;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			name_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		name_valid <= 1'b1;
		name_item <= it;
		do @(posedge clk); while (name_stall);
		score_name_byte(it);
	endtask

	task automatic send_name_buf();
		for (int i = 0; i < name_buf.size(); i++)
			send_byte(name_buf[i], i == name_buf.size() - 1);
	endtask

	task automatic send_text(input string s);
		name_buf.delete();
		for (int i = 0; i < s.len(); i++)
			name_buf.push_back(s[i]);
		send_name_buf();
	endtask

	// Hold the name channel until every score is out and the pipeline is empty
	task automatic quiesce();
		name_valid <= 1'b0;
		while (expected_scores.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_PAT_LO:  query_lo = data;
			REG_PAT_HI:  query_hi = data;
			REG_PAT_LEN: query_len_reg = data[4:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_query(input logic [63:0] lo, input logic [63:0] hi,
		input logic [63:0] len_word);
		quiesce();
		write_reg(REG_PAT_LO, lo);
		write_reg(REG_PAT_HI, hi);
		write_reg(REG_PAT_LEN, len_word);
	endtask

	task automatic set_query(input string s);
		logic [63:0] lo;
		logic [63:0] hi;
		lo = '0;
		hi = '0;
		for (int i = 0; i < s.len() && i < 16; i++)
			if (i < 8)
				lo[8*i +: 8] = s[i];
			else
				hi[8*(i-8) +: 8] = s[i];
		write_query(lo, hi, 64'(s.len()));
	endtask

	// Mostly word characters, some separators and high bytes
	function automatic logic [7:0] random_name_char();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 8'h61 + 8'($urandom_range(0, 25));
			4:          return 8'h41 + 8'($urandom_range(0, 25));
			5:          return 8'h30 + 8'($urandom_range(0, 9));
			6:          return UNDERSCORE;
			7: begin
				case ($urandom_range(0, 3))
					0:       return 8'h20;
					1:       return 8'h2D;
					2:       return 8'h2E;
					default: return 8'h2F;
				endcase
			end
			8:          return 8'($urandom_range(128, 255));
			default:    return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] scramble_case(input logic [7:0] c);
		logic [7:0] f;
		f = lower_case(c);
		if (f >= 8'h61 && f <= 8'h7A && $urandom_range(0, 1))
			return f ^ 8'h20;
		return c;
	endfunction

	task automatic push_query_chars();
		for (int i = 0; i < eff_query_len(); i++)
			name_buf.push_back(scramble_case(stored_query_byte(i)));
	endtask

	task automatic push_fillers(input int n);
		repeat (n) name_buf.push_back(random_name_char());
	endtask

	// Build a candidate name around the current query
	task automatic build_name();
		int r;
		int j;
		r = $urandom_range(0, 99);
		name_buf.delete();
		if (r < 15) begin
			push_query_chars();
		end else if (r < 30) begin
			push_query_chars();
			push_fillers($urandom_range(1, 5));
		end else if (r < 45) begin
			push_fillers($urandom_range(1, 4));
			push_query_chars();
			push_fillers($urandom_range(0, 3));
		end else if (r < 70) begin
			// scattered subsequence
			for (int i = 0; i < eff_query_len(); i++) begin
				push_fillers($urandom_range(0, 2));
				name_buf.push_back(scramble_case(stored_query_byte(i)));
			end
			push_fillers($urandom_range(0, 2));
		end else if (r < 85) begin
			// broken: one character replaced or dropped
			push_query_chars();
			if (name_buf.size() > 0) begin
				j = $urandom_range(0, name_buf.size() - 1);
				if ($urandom_range(0, 1))
					name_buf[j] = random_name_char();
				else if (name_buf.size() > 1)
					name_buf.delete(j);
			end
			push_fillers($urandom_range(0, 2));
		end else if (r < 95) begin
			repeat ($urandom_range(1, 10)) name_buf.push_back(8'($urandom_range(0, 255)));
		end else begin
			// often long enough to saturate the position counter
			push_fillers($urandom_range(20, 40));
			if ($urandom_range(0, 1))
				push_query_chars();
		end
		if (name_buf.size() == 0)
			name_buf.push_back(random_name_char());
	endtask

	// Pick a query setting: random, or one of the extremes
	task automatic pick_query(input int mode);
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] len_word;
		logic [7:0]  ch;
		int          n;
		lo = {$urandom, $urandom};
		hi = {$urandom, $urandom};
		len_word = {$urandom, $urandom};
		n = 0;
		case (mode)
			0: n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
			1: n = 16;
			5: n = 1;
			default: ;
		endcase
		for (int i = 0; i < n; i++) begin
			ch = random_name_char();
			if (i < 8)
				lo[8*i +: 8] = ch;
			else
				hi[8*(i-8) +: 8] = ch;
		end
		case (mode)
			1: len_word[4:0] = $urandom_range(0, 1) ? 5'd31 : 5'($urandom_range(17, 30));
			2: begin
				lo = '1;
				hi = '1;
				len_word[4:0] = 5'd16;
			end
			3: begin
				lo = '0;
				hi = '0;
				len_word[4:0] = 5'd16;
			end
			4: len_word[4:0] = 5'd0;
			default: len_word[4:0] = 5'(n);
		endcase
		write_query(lo, hi, len_word);
	endtask

	// Reset query: everything is included with score zero
	task automatic test_empty_query();
		send_text("a");
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
	endtask

	// Equality, prefix, substring, word-start bonus and a miss
	task automatic test_scoring_rules();
		set_query("ab");
		send_text("AB");
		send_text("abZ");
		send_text("xab");
		send_text("a_b");
		send_text("a-b");
		send_text("ba");
	endtask

	// Bytes above 127 never fold and break words
	task automatic test_high_bytes();
		set_query("a");
		name_buf.delete();
		name_buf.push_back(8'hC1);
		name_buf.push_back(8'h61);
		send_name_buf();
	endtask

	// Change the query between two bytes of one name; state must carry over
	task automatic test_config_mid_name();
		send_byte(8'h61, 1'b0);
		set_query("ab");
		send_byte(8'h62, 1'b1);
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct, input int profile);
		int setting_bytes;
		int mode;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		for (int s = 0; s < 6; s++) begin
			mode = (s < 3) ? 0 : 1 + ((profile * 3 + s - 3) % 5);
			pick_query(mode);
			setting_bytes = 0;
			while (setting_bytes < SETTING_BYTES) begin
				build_name();
				setting_bytes += name_buf.size();
				send_name_buf();
			end
		end
	endtask

	initial begin
		clear_name_state();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 37;
		recv_stall_pct = 68;
		test_empty_query();
		test_scoring_rules();
		test_high_bytes();
		test_config_mid_name();
		test_random_traffic(37, 68, 0);
		test_random_traffic(68, 37, 1);
		test_random_traffic(0, 0, 2);
		name_valid <= 1'b0;
		while (expected_scores.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/fnms_pkg.sv
rtl/core/fnms_cell.sv
rtl/core/fnms_score.sv
rtl/core/fuzzy_name_match_scorer_top.sv
test/fuzzy_name_match_scorer_top_test.sv
